// File: hdl/dtts_pkg.sv
// Package: widths, phase type, character codes and unit factors for the duration parser.
`timescale 1ns / 1ps
package dtts_pkg;

	localparam int RESULT_BITS = 32;
	localparam int MAG_W       = RESULT_BITS - 1;
	localparam int FACTOR_W    = 25;
	localparam int PROD_W      = MAG_W + FACTOR_W;
	localparam int CHAR_W      = 8;
	localparam int STATUS_W    = 2;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [FACTOR_W-1:0] factor_t;
	typedef logic [STATUS_W-1:0] status_t;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_PRE,
		PH_DIGITS,
		PH_POST,
		PH_STOP
	} phase_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_BAD_CHAR = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;

	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_TAB   = 8'h09;
	localparam char_t CH_CR    = 8'h0D;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_UP_Y  = 8'h59;
	localparam char_t CH_UP_M  = 8'h4D;
	localparam char_t CH_UP_D  = 8'h44;
	localparam char_t CH_LO_D  = 8'h64;
	localparam char_t CH_LO_H  = 8'h68;
	localparam char_t CH_LO_M  = 8'h6D;
	localparam char_t CH_LO_S  = 8'h73;

	localparam factor_t F_YEAR   = FACTOR_W'(365 * 24 * 60 * 60);
	localparam factor_t F_MONTH  = FACTOR_W'(31 * 24 * 60 * 60);
	localparam factor_t F_DAY    = FACTOR_W'(24 * 60 * 60);
	localparam factor_t F_HOUR   = FACTOR_W'(60 * 60);
	localparam factor_t F_MINUTE = FACTOR_W'(60);
	localparam factor_t F_SECOND = FACTOR_W'(1);

	function automatic logic is_white(input char_t c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic factor_t unit_factor(input char_t c);
		factor_t f;
		unique case (c)
			CH_UP_Y:          f = F_YEAR;
			CH_UP_M:          f = F_MONTH;
			CH_UP_D, CH_LO_D: f = F_DAY;
			CH_LO_H:          f = F_HOUR;
			CH_LO_M:          f = F_MINUTE;
			CH_LO_S:          f = F_SECOND;
			default:          f = '0;
		endcase
		return f;
	endfunction

endpackage

// File: hdl/duration_text_to_seconds.sv
// Top level: parses a duration text stream, one character per transaction, into signed seconds.
`timescale 1ns / 1ps
//  channel   dir  tdata                      tuser          tlast
//  s_axis    in   [7:0] char_code            -              last
//  m_axis    out  [31:0] seconds (signed)    [1:0] status   -
//
//  One character per cycle while no stalled result holds a last character; a character
//  waits in the input register and is folded into the running state by the segment multiply-add there.
//  The result is registered and made valid when its last character leaves the input register.
//  arst_n clears the parse state and both valid flags.
//  A stalled result blocks only the last character of the next text.
module duration_text_to_seconds import dtts_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] char_code
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [RESULT_BITS-1:0] m_axis_tdata,   // [RESULT_BITS-1:0] seconds
	output logic [STATUS_W-1:0]    m_axis_tuser    // [1:0] status
);

	logic                   valid_s1;
	char_t                  char_s1;
	logic                   last_s1;
	logic                   adv_s1;

	logic [MAG_W-1:0]       total_q;
	logic [MAG_W-1:0]       seg_q;
	phase_t                 phase_q;
	logic                   neg_q;
	status_t                err_q;
	logic                   ended_q;

	logic [MAG_W-1:0]       total_d;
	logic [MAG_W-1:0]       seg_d;
	phase_t                 phase_d;
	logic                   neg_d;
	status_t                err_d;
	logic                   ended_d;

	logic                   out_valid_q;
	logic [RESULT_BITS-1:0] seconds_q;
	status_t                status_q;

	factor_t                factor;
	factor_t                close_mf;
	logic                   close_req;
	logic                   seg_en;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [MAG_W+3:0]       dig_sum;
	logic                   dig_ovf;
	logic [PROD_W-1:0]      prod;
	logic                   prod_ovf;
	logic [MAG_W:0]         close_sum;
	logic [MAG_W:0]         fin_sum;
	logic [MAG_W-1:0]       res_total;
	status_t                res_err;
	logic                   res_neg;
	logic [RESULT_BITS-1:0] res_seconds;

	assign adv_s1        = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	assign factor   = unit_factor(char_s1);
	assign is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign digit    = char_s1[3:0];
	assign dig_sum  = ({4'b0, seg_q} << 3) + ({4'b0, seg_q} << 1)
		+ {{MAG_W{1'b0}}, digit};
	assign dig_ovf  = |dig_sum[MAG_W+3:MAG_W];
	assign prod     = PROD_W'(seg_q) * PROD_W'(close_mf);
	assign prod_ovf = |prod[PROD_W-1:MAG_W];
	assign close_sum = {1'b0, total_q} + {1'b0, prod[MAG_W-1:0]};

	// next state
	always_comb begin
		total_d   = total_q;
		seg_d     = seg_q;
		phase_d   = phase_q;
		neg_d     = neg_q;
		err_d     = err_q;
		ended_d   = ended_q;
		close_req = 1'b0;
		close_mf  = F_SECOND;
		seg_en    = 1'b0;
		if (!ended_q && phase_q != PH_STOP) begin
			if (char_s1 == CH_NUL) begin
				close_req = 1'b1;
				ended_d   = 1'b1;
			end else begin
				seg_en = 1'b1;
				if (phase_q == PH_LEAD) begin
					if (is_white(char_s1)) begin
						seg_en = 1'b0;
					end else if (char_s1 == CH_MINUS) begin
						neg_d   = 1'b1;
						phase_d = PH_PRE;
						seg_en  = 1'b0;
					end else begin
						phase_d = PH_PRE;
					end
				end
				if (seg_en) begin
					priority if (factor != '0) begin
						close_req = 1'b1;
						close_mf  = factor;
					end else if (is_white(char_s1)) begin
						if (phase_q == PH_DIGITS) begin
							phase_d = PH_POST;
						end
					end else if (is_digit) begin
						priority if (phase_q == PH_POST) begin
							err_d   = ST_BAD_CHAR;
							phase_d = PH_STOP;
						end else if (dig_ovf) begin
							err_d   = ST_OVERFLOW;
							phase_d = PH_STOP;
						end else begin
							seg_d   = dig_sum[MAG_W-1:0];
							phase_d = PH_DIGITS;
						end
					end else begin
						err_d   = ST_BAD_CHAR;
						phase_d = PH_STOP;
					end
				end
			end
			if (close_req) begin
				if ((phase_q == PH_DIGITS || phase_q == PH_POST)
					&& (prod_ovf || close_sum[MAG_W])) begin
					err_d   = ST_OVERFLOW;
					phase_d = PH_STOP;
				end else begin
					if (phase_q == PH_DIGITS || phase_q == PH_POST) begin
						total_d = close_sum[MAG_W-1:0];
					end
					seg_d   = '0;
					phase_d = PH_PRE;
				end
			end
		end
	end

	// close the open segment at the end of the buffer
	assign fin_sum = {1'b0, total_q} + {1'b0, seg_d};

	always_comb begin
		res_total = total_d;
		res_err   = err_d;
		if (!ended_d && (phase_d == PH_DIGITS || phase_d == PH_POST)) begin
			if (fin_sum[MAG_W]) begin
				res_err = ST_OVERFLOW;
			end else begin
				res_total = fin_sum[MAG_W-1:0];
			end
		end
	end

	assign res_neg     = neg_d;
	assign res_seconds = res_neg ? (RESULT_BITS'(0) - {1'b0, res_total}) : {1'b0, res_total};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			seg_q   <= '0;
			phase_q <= PH_LEAD;
			neg_q   <= 1'b0;
			err_q   <= ST_OK;
			ended_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				total_q <= '0;
				seg_q   <= '0;
				phase_q <= PH_LEAD;
				neg_q   <= 1'b0;
				err_q   <= ST_OK;
				ended_q <= 1'b0;
			end else begin
				total_q <= total_d;
				seg_q   <= seg_d;
				phase_q <= phase_d;
				neg_q   <= neg_d;
				err_q   <= err_d;
				ended_q <= ended_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			seconds_q <= res_seconds;
			status_q  <= res_err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = seconds_q;
	assign m_axis_tuser  = status_q;

	a_ended_left_lead: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> phase_q != PH_LEAD)
		else $error("text end seen while still in leading white space");

	a_err_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK) |-> phase_q == PH_STOP)
		else $error("error recorded without stopping the parse");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> m_axis_tvalid)
		else $error("last character did not produce a result");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (phase_q == PH_LEAD && total_q == '0 && !neg_q && !ended_q))
		else $error("parse state not cleared after result");

endmodule

// File: tb/tb_duration_text_to_seconds.sv
// Testbench: streams duration texts into duration_text_to_seconds and checks each total and status.
`timescale 1ns / 1ps
module tb_duration_text_to_seconds;
	import dtts_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_ITEMS = 900;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 20;
	localparam logic [63:0] MAG_MAX = (64'd1 << (RESULT_BITS - 1)) - 64'd1;

	typedef struct packed {
		logic [RESULT_BITS-1:0] seconds;
		status_t                status;
	} duration_t;

	typedef struct packed {
		char_t     ch;
		logic      last;
		logic      typed;
		duration_t result;
	} stim_row_t;

	localparam duration_t NO_TYPED = '0;
	localparam char_t UNIT_CHARS [7] = '{CH_UP_Y, CH_UP_M, CH_UP_D, CH_LO_D, CH_LO_H, CH_LO_M,
		CH_LO_S};

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	char_t                  s_axis_tdata;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [RESULT_BITS-1:0] m_axis_tdata;
	status_t                m_axis_tuser;

	duration_t pending_durations[$];
	char_t     text_q[$];
	stim_row_t directed_rows [25];

	logic [63:0] acc_total;
	logic [63:0] seg_digits;
	phase_t      parse_phase;
	logic        sign_seen;
	logic        text_done;
	status_t     parse_err;

	int mismatches = 0;
	int results_seen = 0;
	int texts_sent = 0;
	int cycle_count = 0;
	int status_tally [4] = '{0, 0, 0, 0};
	int send_quiet = 0;
	int recv_quiet = 0;
	bit long_hold_pending = 0;

	duration_text_to_seconds dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_blank(input char_t c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [63:0] unit_seconds(input char_t c);
		case (c)
			CH_UP_Y:          return 64'(F_YEAR);
			CH_UP_M:          return 64'(F_MONTH);
			CH_UP_D, CH_LO_D: return 64'(F_DAY);
			CH_LO_H:          return 64'(F_HOUR);
			CH_LO_M:          return 64'(F_MINUTE);
			CH_LO_S:          return 64'(F_SECOND);
			default:          return 64'd0;
		endcase
	endfunction

	function automatic char_t digit_of(input int n);
		return CH_ZERO + char_t'(n);
	endfunction

	function automatic char_t blank_char();
		if ($urandom_range(0, 5) == 5) begin
			return CH_SPACE;
		end
		return CH_TAB + char_t'($urandom_range(0, 4));
	endfunction

	// zero waits for a stretch now and then, otherwise a fresh draw per transaction
	function automatic int pick_wait(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			quiet_left = $urandom_range(20, 40);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	task automatic clear_parse();
		acc_total   = '0;
		seg_digits  = '0;
		parse_phase = PH_LEAD;
		sign_seen   = 1'b0;
		parse_err   = ST_OK;
		text_done   = 1'b0;
	endtask

	task automatic halt_parse(input status_t code);
		parse_err   = code;
		parse_phase = PH_STOP;
	endtask

	task automatic fold_segment(input logic [63:0] mult);
		logic [63:0] prod;
		if (parse_phase == PH_DIGITS || parse_phase == PH_POST) begin
			if (seg_digits > MAG_MAX / mult) begin
				halt_parse(ST_OVERFLOW);
				return;
			end
			prod = seg_digits * mult;
			if (prod > MAG_MAX - acc_total) begin
				halt_parse(ST_OVERFLOW);
				return;
			end
			acc_total = acc_total + prod;
		end
		seg_digits = '0;
		if (parse_phase != PH_STOP) begin
			parse_phase = PH_PRE;
		end
	endtask

	task automatic predict_char(input char_t ch, input logic last, output bit produced,
		output duration_t res);
		logic [63:0] mult;
		logic [63:0] digit;
		logic [63:0] signed_total;
		bit          in_segment;
		produced = 1'b0;
		res      = '0;
		if (!text_done && parse_phase != PH_STOP) begin
			if (ch == CH_NUL) begin
				fold_segment(64'd1);
				text_done = 1'b1;
			end else begin
				in_segment = 1'b1;
				if (parse_phase == PH_LEAD) begin
					if (is_blank(ch)) begin
						in_segment = 1'b0;
					end else if (ch == CH_MINUS) begin
						sign_seen   = 1'b1;
						parse_phase = PH_PRE;
						in_segment  = 1'b0;
					end else begin
						parse_phase = PH_PRE;
					end
				end
				if (in_segment) begin
					mult = unit_seconds(ch);
					if (mult != 64'd0) begin
						fold_segment(mult);
					end else if (is_blank(ch)) begin
						if (parse_phase == PH_DIGITS) begin
							parse_phase = PH_POST;
						end
					end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
						digit = 64'(ch - CH_ZERO);
						if (parse_phase == PH_POST) begin
							halt_parse(ST_BAD_CHAR);
						end else if (seg_digits > (MAG_MAX - digit) / 64'd10) begin
							halt_parse(ST_OVERFLOW);
						end else begin
							seg_digits  = seg_digits * 64'd10 + digit;
							parse_phase = PH_DIGITS;
						end
					end else begin
						halt_parse(ST_BAD_CHAR);
					end
				end
			end
		end
		if (last) begin
			if (!text_done && parse_phase != PH_STOP) begin
				fold_segment(64'd1);
			end
			signed_total = sign_seen ? (64'd0 - acc_total) : acc_total;
			res.seconds  = signed_total[RESULT_BITS-1:0];
			res.status   = parse_err;
			produced     = 1'b1;
			clear_parse();
		end
	endtask

	// entered and left at a falling edge
	task automatic send_char(input char_t ch, input logic last, input logic typed,
		input duration_t typed_result);
		int        gap;
		bit        produced;
		duration_t res;
		gap = pick_wait(send_quiet);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		predict_char(ch, last, produced, res);
		if (produced) begin
			pending_durations.push_back(typed ? typed_result : res);
		end
		@(negedge clk);
	endtask

	// mostly well-formed texts, some with a broken spot, some plain noise
	task automatic compose_text(output int counted);
		int kind;
		int nseg;
		int ndig;
		int pos;
		text_q.delete();
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(1, 6)) text_q.push_back(char_t'($urandom_range(0, 255)));
			counted = text_q.size();
			return;
		end
		repeat ($urandom_range(0, 2)) text_q.push_back(blank_char());
		if ($urandom_range(0, 1) == 1) begin
			text_q.push_back(CH_MINUS);
		end
		nseg = $urandom_range(1, 3);
		for (int seg = 0; seg < nseg; seg++) begin
			if ($urandom_range(0, 3) == 0) begin
				text_q.push_back(blank_char());
			end
			case ($urandom_range(0, 9))
				0:       ndig = 0;
				1:       ndig = $urandom_range(6, 10);
				default: ndig = $urandom_range(1, 3);
			endcase
			repeat (ndig) text_q.push_back(digit_of($urandom_range(0, 9)));
			if ($urandom_range(0, 3) == 0) begin
				text_q.push_back(blank_char());
			end
			if (seg < nseg - 1 || $urandom_range(0, 1) == 1) begin
				text_q.push_back(UNIT_CHARS[$urandom_range(0, 6)]);
			end
		end
		if (kind >= 7) begin
			pos = $urandom_range(0, text_q.size());
			case ($urandom_range(0, 2))
				0: text_q.insert(pos, char_t'($urandom_range(0, 255)));
				1: begin
					text_q.insert(pos, digit_of($urandom_range(0, 9)));
					text_q.insert(pos, blank_char());
				end
				default: text_q.insert(pos, CH_MINUS);
			endcase
		end
		counted = text_q.size();
		if ($urandom_range(0, 3) == 0) begin
			text_q.push_back(CH_NUL);
			repeat ($urandom_range(0, 2)) text_q.push_back(char_t'($urandom_range(0, 255)));
		end
		if (text_q.size() == 0) begin
			text_q.push_back(CH_NUL);
		end
	endtask

	initial begin
		int counted;
		int budget;
		bit second_hold;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = CH_NUL;
		s_axis_tlast  = 1'b0;
		arst_n        = 1'b0;
		second_hold   = 1'b0;
		clear_parse();
		directed_rows = '{
			'{digit_of(7), 1'b1, 1'b1, '{RESULT_BITS'(7), ST_OK}},
			'{8'hFF,       1'b1, 1'b1, '{RESULT_BITS'(0), ST_BAD_CHAR}},
			'{CH_NUL,      1'b1, 1'b1, '{RESULT_BITS'(0), ST_OK}},
			'{digit_of(9), 1'b0, 1'b0, NO_TYPED},
			'{digit_of(9), 1'b0, 1'b0, NO_TYPED},
			'{CH_UP_Y,     1'b1, 1'b1, '{RESULT_BITS'(0), ST_OVERFLOW}},
			'{CH_TAB,      1'b0, 1'b0, NO_TYPED},
			'{CH_MINUS,    1'b0, 1'b0, NO_TYPED},
			'{CH_LO_D,     1'b0, 1'b0, NO_TYPED},
			'{digit_of(1), 1'b0, 1'b0, NO_TYPED},
			'{CH_UP_Y,     1'b0, 1'b0, NO_TYPED},
			'{CH_SPACE,    1'b0, 1'b0, NO_TYPED},
			'{digit_of(3), 1'b0, 1'b0, NO_TYPED},
			'{CH_UP_M,     1'b0, 1'b0, NO_TYPED},
			'{digit_of(2), 1'b0, 1'b0, NO_TYPED},
			'{CH_UP_D,     1'b0, 1'b0, NO_TYPED},
			'{digit_of(4), 1'b0, 1'b0, NO_TYPED},
			'{CH_LO_H,     1'b0, 1'b0, NO_TYPED},
			'{digit_of(5), 1'b0, 1'b0, NO_TYPED},
			'{CH_LO_M,     1'b0, 1'b0, NO_TYPED},
			'{digit_of(6), 1'b0, 1'b0, NO_TYPED},
			'{CH_SPACE,    1'b0, 1'b0, NO_TYPED},
			'{CH_LO_S,     1'b0, 1'b0, NO_TYPED},
			'{CH_NUL,      1'b0, 1'b0, NO_TYPED},
			'{8'h78,       1'b1, 1'b0, NO_TYPED}
		};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[i]) begin
			send_char(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].result);
		end
		long_hold_pending = 1'b1;
		budget = 0;
		while (budget < RANDOM_ITEMS) begin
			compose_text(counted);
			budget += counted;
			texts_sent++;
			if (!second_hold && budget >= RANDOM_ITEMS / 2) begin
				long_hold_pending = 1'b1;
				second_hold       = 1'b1;
			end
			foreach (text_q[i]) begin
				send_char(text_q[i], logic'(i == text_q.size() - 1), 1'b0, NO_TYPED);
			end
		end
		s_axis_tvalid <= 1'b0;
		while (pending_durations.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("Ran %0d directed characters and %0d random texts; %0d results checked.",
			$size(directed_rows), texts_sent, results_seen);
		$display("Results by status: %0d ok, %0d bad character, %0d overflow; %0d mismatches.",
			status_tally[ST_OK], status_tally[ST_BAD_CHAR], status_tally[ST_OVERFLOW],
			mismatches);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = pick_wait(recv_quiet);
			if (long_hold_pending) begin
				// hold off while the sender keeps offering, so the input stalls
				long_hold_pending = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (stall != 0) begin
				m_axis_tready <= 1'b0;
				do @(posedge clk); while (!m_axis_tvalid);
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		duration_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_durations.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual seconds=%0d status=%0d",
					$time, $signed(m_axis_tdata), m_axis_tuser);
				mismatches++;
			end else begin
				want = pending_durations.pop_front();
				results_seen++;
				status_tally[want.status]++;
				if (m_axis_tdata !== want.seconds) begin
					$display("%0t: seconds mismatch, expected %0d, actual %0d", $time,
						$signed(want.seconds), $signed(m_axis_tdata));
					mismatches++;
				end
				if (m_axis_tuser !== want.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d", $time,
						want.status, m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d results still outstanding", $time,
			cycle_count, pending_durations.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hdl/dtts_pkg.sv
hdl/duration_text_to_seconds.sv
tb/tb_duration_text_to_seconds.sv
